// ===== design/cll_pkg.sv =====
// Shared types, codes and defaults for the circular list block.
`default_nettype none
package cll_pkg;

    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;
    localparam int IO_VALUE_W      = 32;
    localparam int IO_COUNT_W      = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_TAIL = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_FIRST    = 3'd2,
        CMD_NEXT     = 3'd3,
        CMD_REMOVE   = 3'd4,
        CMD_COUNT    = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_CURSOR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EXEC2,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic exec2;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic second_read;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== design/cll_ctrl.sv =====
// Sequencing state machine and result handshake for the circular list block.
`default_nettype none
module cll_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire cll_pkg::dp_status_t dp_status,
    output cll_pkg::ctrl_cmd_t      ctrl_cmd
);

    cll_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cll_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign fire = (state_reg == cll_pkg::S_FINISH) && (!out_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cll_pkg::S_IDLE: begin
                if (s_valid) state_next = cll_pkg::S_EXEC;
            end
            cll_pkg::S_EXEC: begin
                state_next = dp_status.second_read ? cll_pkg::S_EXEC2 : cll_pkg::S_FINISH;
            end
            cll_pkg::S_EXEC2: begin
                state_next = cll_pkg::S_FINISH;
            end
            cll_pkg::S_FINISH: begin
                if (fire) state_next = cll_pkg::S_IDLE;
            end
            default: begin
                state_next = cll_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready          = (state_reg == cll_pkg::S_IDLE);
        ctrl_cmd.capture = s_valid && (state_reg == cll_pkg::S_IDLE);
        ctrl_cmd.exec    = (state_reg == cll_pkg::S_EXEC);
        ctrl_cmd.exec2   = (state_reg == cll_pkg::S_EXEC2);
        ctrl_cmd.finish  = fire;
        if (fire)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_valid = out_valid_reg;

`ifndef SYNTH
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("finished command did not raise m_valid");
`endif

endmodule
`default_nettype wire

// ===== design/cll_dp.sv =====
// List state, node pool memories and result registers for the circular list block.
`default_nettype none
module cll_dp #(
    parameter int CAPACITY    = cll_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = cll_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire cll_pkg::ctrl_cmd_t                  ctrl_cmd,
    output cll_pkg::dp_status_t                      dp_status,
    input  wire logic [cll_pkg::CMD_W-1:0]           s_cmd,
    input  wire logic signed [cll_pkg::IO_VALUE_W-1:0] s_value_in,
    output logic [cll_pkg::STATUS_W-1:0]             m_status,
    output logic signed [cll_pkg::IO_VALUE_W-1:0]    m_value_out,
    output logic [cll_pkg::IO_COUNT_W-1:0]           m_element_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int VW = VALUE_WIDTH;
    localparam int OW = cll_pkg::IO_VALUE_W;
    localparam int CW = cll_pkg::IO_COUNT_W;
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);
    localparam logic [PW-1:0] ONE = PW'(1);

    // pool memories
    logic [PW-1:0] link_mem [CAPACITY];
    logic [VW-1:0] val_mem  [CAPACITY];

    logic [PW-1:0] link_rd_reg;
    logic [VW-1:0] val_rd_reg;

    // command and list registers
    logic [cll_pkg::CMD_W-1:0] cmd_reg;
    logic [OW-1:0]             vin_reg;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] free_reg, free_next;
    logic [PW-1:0] fresh_reg, fresh_next;
    logic [PW-1:0] count_reg, count_next;

    logic [cll_pkg::STATUS_W-1:0] status_reg;
    logic [OW-1:0]                value_out_reg;
    logic [CW-1:0]                ecount_reg;

    // memory port controls
    logic          link_we, link_re, val_we, val_re;
    logic [IW-1:0] link_wa, link_ra, val_wa, val_ra;
    logic [PW-1:0] link_wd;
    logic [VW-1:0] val_wd;

    logic [cll_pkg::STATUS_W-1:0] status_c;
    logic                         ok, empty, is_ins, is_first, is_next, is_remove;
    logic [VW+OW-1:0]             vin_ext;
    logic [VW+OW-1:0]             rd_ext;
    logic [PW+CW-1:0]             cnt_ext;
    logic [OW-1:0]                value_c;

    always_comb begin
        is_ins    = (cmd_reg == cll_pkg::CMD_INS_TAIL) || (cmd_reg == cll_pkg::CMD_INS_HEAD);
        is_first  = (cmd_reg == cll_pkg::CMD_FIRST);
        is_next   = (cmd_reg == cll_pkg::CMD_NEXT);
        is_remove = (cmd_reg == cll_pkg::CMD_REMOVE);
        empty     = (tail_reg >= NIL);
        status_c  = cll_pkg::ST_OK;
        if (is_ins) begin
            if ((count_reg >= NIL) || (free_reg >= NIL)) status_c = cll_pkg::ST_FULL;
        end else if (is_first) begin
            if (empty) status_c = cll_pkg::ST_EMPTY;
        end else if (is_next) begin
            if (empty)
                status_c = cll_pkg::ST_EMPTY;
            else if (cur_reg >= NIL)
                status_c = cll_pkg::ST_NO_CURSOR;
        end else if (is_remove) begin
            if (empty)
                status_c = cll_pkg::ST_EMPTY;
            else if ((cur_reg >= NIL) || (prev_reg >= NIL))
                status_c = cll_pkg::ST_NO_CURSOR;
        end
        ok = (status_c == cll_pkg::ST_OK);
        dp_status.second_read = is_next && ok;
        vin_ext = {{VW{1'b0}}, vin_reg};
        rd_ext  = {{OW{val_rd_reg[VW-1]}}, val_rd_reg};
    end

    // memory accesses and next state
    always_comb begin
        link_we    = 1'b0;
        link_re    = 1'b0;
        val_we     = 1'b0;
        val_re     = 1'b0;
        link_wa    = free_reg[IW-1:0];
        link_ra    = free_reg[IW-1:0];
        val_wa     = free_reg[IW-1:0];
        val_ra     = head_reg[IW-1:0];
        link_wd    = free_reg;
        val_wd     = vin_ext[VW-1:0];
        tail_next  = tail_reg;
        head_next  = head_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        free_next  = free_reg;
        fresh_next = fresh_reg;
        count_next = count_reg;
        value_c    = '0;

        if (ctrl_cmd.exec && ok) begin
            if (is_ins) begin
                // store value, read free successor, hook new node behind the tail
                val_we  = 1'b1;
                link_re = 1'b1;
                link_we = !empty;
                link_wa = tail_reg[IW-1:0];
                link_wd = free_reg;
            end else if (is_first) begin
                val_re = 1'b1;
                val_ra = head_reg[IW-1:0];
            end else if (is_next) begin
                link_re = 1'b1;
                link_ra = cur_reg[IW-1:0];
            end else if (is_remove) begin
                // read-first port: old link comes back while the node joins the free chain
                link_re = 1'b1;
                link_ra = cur_reg[IW-1:0];
                val_re  = 1'b1;
                val_ra  = cur_reg[IW-1:0];
                link_we = 1'b1;
                link_wa = cur_reg[IW-1:0];
                link_wd = free_reg;
            end
        end

        if (ctrl_cmd.exec2) begin
            val_re = 1'b1;
            val_ra = link_rd_reg[IW-1:0];
        end

        if (ctrl_cmd.finish && ok) begin
            if (is_ins) begin
                link_we = 1'b1;
                link_wa = free_reg[IW-1:0];
                link_wd = empty ? free_reg : head_reg;
                if (free_reg == fresh_reg) begin
                    free_next  = free_reg + ONE;
                    fresh_next = free_reg + ONE;
                end else begin
                    free_next = link_rd_reg;
                end
                if (empty) begin
                    tail_next = free_reg;
                    head_next = free_reg;
                end else begin
                    if ((prev_reg == tail_reg) && (cur_reg < NIL)) prev_next = free_reg;
                    if (cmd_reg == cll_pkg::CMD_INS_TAIL)
                        tail_next = free_reg;
                    else
                        head_next = free_reg;
                end
                count_next = count_reg + ONE;
            end else if (is_first) begin
                prev_next = tail_reg;
                cur_next  = head_reg;
                value_c   = rd_ext[OW-1:0];
            end else if (is_next) begin
                prev_next = cur_reg;
                cur_next  = link_rd_reg;
                value_c   = rd_ext[OW-1:0];
            end else if (is_remove) begin
                value_c = rd_ext[OW-1:0];
                if (cur_reg == tail_reg)
                    tail_next = (link_rd_reg == cur_reg) ? NIL : prev_reg;
                if (link_rd_reg != cur_reg) begin
                    link_we = 1'b1;
                    link_wa = prev_reg[IW-1:0];
                    link_wd = link_rd_reg;
                end
                if (cur_reg == head_reg) head_next = link_rd_reg;
                cur_next   = (link_rd_reg == cur_reg) ? NIL : prev_reg;
                prev_next  = NIL;
                free_next  = cur_reg;
                count_next = count_reg - ONE;
            end
        end
        cnt_ext = {{CW{1'b0}}, count_next};
    end

    always_ff @(posedge aclk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        if (link_re) link_rd_reg <= link_mem[link_ra];
        if (val_we) val_mem[val_wa] <= val_wd;
        if (val_re) val_rd_reg <= val_mem[val_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg  <= NIL;
            head_reg  <= '0;
            cur_reg   <= NIL;
            prev_reg  <= NIL;
            free_reg  <= '0;
            fresh_reg <= '0;
            count_reg <= '0;
        end else if (ctrl_cmd.finish) begin
            tail_reg  <= tail_next;
            head_reg  <= head_next;
            cur_reg   <= cur_next;
            prev_reg  <= prev_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            count_reg <= count_next;
        end
    end

    // captured command and result payload
    always_ff @(posedge aclk) begin
        if (ctrl_cmd.capture) begin
            cmd_reg <= s_cmd;
            vin_reg <= s_value_in;
        end
        if (ctrl_cmd.finish) begin
            status_reg    <= status_c;
            value_out_reg <= value_c;
            ecount_reg    <= cnt_ext[CW-1:0];
        end
    end

    assign m_status        = status_reg;
    assign m_value_out     = value_out_reg;
    assign m_element_count = ecount_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NIL)
        else $error("element count above capacity");
    a_empty_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (tail_reg == NIL) == (count_reg == '0))
        else $error("tail marker disagrees with element count");
    a_full_no_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == NIL) |-> (free_reg == NIL))
        else $error("full pool still has a free node");
    a_cursor_needs_list: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_reg != NIL) |-> (tail_reg != NIL))
        else $error("cursor held on an empty list");
`endif

endmodule
`default_nettype wire

// ===== design/circular_list_with_cursor_top.sv =====
// Top level of the circular singly linked list with traversal cursor.
//
// Usage:
//   Input channel (s_valid/s_ready, s_cmd, s_value_in) takes one command per
//   transfer: insert at tail or head, move cursor to first or next element,
//   remove the element under the cursor, or read the element count. Codes 6
//   and 7 behave as count.
//   Result channel (m_valid/m_ready, m_status, m_value_out, m_element_count)
//   returns exactly one result per command, in order.
//   Sequencing: each command passes an exec step and a finish step (next adds
//   a second exec step, as it reads the link and then the value from the
//   node memories, one after the other). A new command is taken only once
//   the block is back in idle. The result is registered in the finish step.
//   Stall: the result sits in an output register; a new command is taken
//   while it waits, and the block holds that command's finish step until the
//   pending result is transferred.
//   Reset (aresetn low, synchronous) empties the list, clears the cursor and
//   rebuilds the free chain at once; the node pool needs no clearing pass.
`default_nettype none
module circular_list_with_cursor_top #(
    parameter int CAPACITY    = cll_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = cll_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [cll_pkg::CMD_W-1:0]             s_cmd,
    input  wire logic signed [cll_pkg::IO_VALUE_W-1:0] s_value_in,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [cll_pkg::STATUS_W-1:0]               m_status,
    output logic signed [cll_pkg::IO_VALUE_W-1:0]      m_value_out,
    output logic [cll_pkg::IO_COUNT_W-1:0]             m_element_count
);

    cll_pkg::ctrl_cmd_t  ctrl_cmd;
    cll_pkg::dp_status_t dp_status;

    // sequencing and handshake
    cll_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd)
    );

    // list state, node pool and result payload
    cll_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl_cmd        (ctrl_cmd),
        .dp_status       (dp_status),
        .s_cmd           (s_cmd),
        .s_value_in      (s_value_in),
        .m_status        (m_status),
        .m_value_out     (m_value_out),
        .m_element_count (m_element_count)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the circular linked list with a traversal cursor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import cll_pkg::*;

    // Predictor sizes follow the block's default parameters.
    localparam int         POOL_SIZE   = DEF_CAPACITY;
    localparam logic [4:0] NO_NODE     = 5'(POOL_SIZE);
    localparam int         RANDOM_CMDS = 1100;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         SETTLE_CYCLES = 8;

    // Command codes outside the defined set; the block treats them as count.
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    typedef struct {
        status_t                       status;
        logic signed [IO_VALUE_W-1:0]  value;
        logic [IO_COUNT_W-1:0]         count;
    } list_result_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [CMD_W-1:0]              s_cmd;
    logic signed [IO_VALUE_W-1:0]  s_value_in;
    logic                          m_valid;
    logic                          m_ready;
    logic [STATUS_W-1:0]           m_status;
    logic signed [IO_VALUE_W-1:0]  m_value_out;
    logic [IO_COUNT_W-1:0]         m_element_count;

    // Predictor copy of the list: node pool, free chain, tail and cursor.
    logic [IO_VALUE_W-1:0] pool_value [POOL_SIZE];
    logic [4:0]            pool_link  [POOL_SIZE];
    logic [4:0]            free_ptr;
    logic [4:0]            tail_ptr;
    logic [4:0]            cursor_ptr;
    logic [4:0]            prev_ptr;
    logic [4:0]            list_size;

    list_result_t pending_results [$];
    list_result_t want_res;
    int           mismatches;
    int           cmds_sent;
    int           cycle_count;
    bit           no_idle;

    circular_list_with_cursor_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_value_in      (s_value_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_value_out     (m_value_out),
        .m_element_count (m_element_count)
    );

    // 8 ns clock: low half then high half.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Abort a hung run; the limit sits far above the slowest legal run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Advance the list copy by one command and queue the result it must produce.
    task automatic apply_list_cmd(input logic [CMD_W-1:0] op,
                                  input logic [IO_VALUE_W-1:0] val);
        list_result_t res;
        logic [4:0]   node;
        logic [4:0]   tail;
        logic [4:0]   victim;
        res.status = ST_OK;
        res.value  = '0;
        case (op)
            CMD_INS_TAIL, CMD_INS_HEAD: begin
                if (list_size >= POOL_SIZE || free_ptr >= NO_NODE) begin
                    res.status = ST_FULL;
                end else begin
                    node = free_ptr;
                    free_ptr = pool_link[node];
                    pool_value[node] = val;
                    if (tail_ptr >= NO_NODE) begin
                        pool_link[node] = node;
                        tail_ptr = node;
                    end else begin
                        tail = tail_ptr;
                        pool_link[node] = pool_link[tail];
                        pool_link[tail] = node;
                        // New node lands just before the cursor: it becomes the predecessor.
                        if (prev_ptr == tail && cursor_ptr < NO_NODE)
                            prev_ptr = node;
                        if (op == CMD_INS_TAIL)
                            tail_ptr = node;
                    end
                    list_size++;
                end
            end
            CMD_FIRST: begin
                if (tail_ptr >= NO_NODE) begin
                    res.status = ST_EMPTY;
                end else begin
                    prev_ptr   = tail_ptr;
                    cursor_ptr = pool_link[tail_ptr];
                    res.value  = pool_value[cursor_ptr];
                end
            end
            CMD_NEXT: begin
                if (tail_ptr >= NO_NODE) begin
                    res.status = ST_EMPTY;
                end else if (cursor_ptr >= NO_NODE) begin
                    res.status = ST_NO_CURSOR;
                end else begin
                    prev_ptr   = cursor_ptr;
                    cursor_ptr = pool_link[cursor_ptr];
                    res.value  = pool_value[cursor_ptr];
                end
            end
            CMD_REMOVE: begin
                if (tail_ptr >= NO_NODE) begin
                    res.status = ST_EMPTY;
                end else if (cursor_ptr >= NO_NODE || prev_ptr >= NO_NODE) begin
                    res.status = ST_NO_CURSOR;
                end else begin
                    victim    = cursor_ptr;
                    res.value = pool_value[victim];
                    if (victim == tail_ptr)
                        tail_ptr = (pool_link[victim] == victim) ? NO_NODE : prev_ptr;
                    pool_link[prev_ptr] = pool_link[victim];
                    cursor_ptr = prev_ptr;
                    prev_ptr   = NO_NODE;
                    pool_link[victim] = free_ptr;
                    free_ptr = victim;
                    if (list_size > 0)
                        list_size--;
                    if (tail_ptr >= NO_NODE)
                        cursor_ptr = NO_NODE;
                end
            end
            default: begin
                // count and the spare codes leave the list alone
            end
        endcase
        res.count = list_size;
        pending_results.push_back(res);
    endtask

    // Send one command: idle for a random gap, then hold valid until the transfer.
    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [IO_VALUE_W-1:0] val);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_cmd      <= op;
        s_value_in <= val;
        do @(posedge aclk); while (!s_ready);
        apply_list_cmd(op, val);
        cmds_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and hold off until every queued result has been transferred.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly random values, with the corner values mixed in.
    function automatic logic [IO_VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Any 3-bit code, defined or not.
    function automatic logic [CMD_W-1:0] CMD_CMD_W_ANY();
        return CMD_W'($urandom_range(0, 7));
    endfunction

    // Empty list: first, next and remove all report empty; spare codes 6 and 7 follow.
    task automatic test_empty_list();
        send_cmd(CMD_FIRST, pick_value());
        send_cmd(CMD_NEXT, pick_value());
        send_cmd(CMD_REMOVE, pick_value());
        send_cmd(CMD_SPARE6, pick_value());
        send_cmd(CMD_SPARE7, pick_value());
    endtask

    // Cursor corner cases on a one- and two-element list.
    task automatic test_cursor_cases();
        send_cmd(CMD_INS_TAIL, 32'h8000_0000);
        send_cmd(CMD_NEXT, 32'h0);                // no cursor yet
        send_cmd(CMD_FIRST, 32'h0);
        send_cmd(CMD_INS_HEAD, 32'h7fff_ffff);    // lands right before the cursor
        send_cmd(CMD_REMOVE, 32'h0);              // removes the tail, tail moves back
        send_cmd(CMD_REMOVE, 32'h0);              // second remove without a move
        send_cmd(CMD_NEXT, 32'h0);
        send_cmd(CMD_REMOVE, 32'h0);              // last element, cursor cleared
        send_cmd(CMD_COUNT, 32'h0);
    endtask

    // Fill the pool with corner values, then try both inserts on a full pool.
    task automatic test_fill_to_full();
        logic [IO_VALUE_W-1:0] corner [7];
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                   32'h1, 32'haaaa_aaaa, 32'h5555_5555};
        for (int i = 0; i < POOL_SIZE; i++)
            send_cmd(i[0] ? CMD_INS_HEAD : CMD_INS_TAIL, (i < 7) ? corner[i] : pick_value());
        send_cmd(CMD_INS_TAIL, pick_value());
        send_cmd(CMD_INS_HEAD, pick_value());
    endtask

    // Pause until the pipe is empty, then drain the full list back to back.
    task automatic test_drain_after_pause();
        wait_all_results();
        no_idle = 1'b1;
        send_cmd(CMD_FIRST, pick_value());
        while (list_size != 0) begin
            send_cmd(CMD_REMOVE, pick_value());
            if (list_size != 0)
                send_cmd(CMD_NEXT, pick_value());
        end
        no_idle = 1'b0;
    endtask

    // Random traffic built from insert bursts, walks, remove runs and noise.
    task automatic test_random_traffic(input int target);
        int pick;
        int ins_weight;
        int len;
        while (cmds_sent < target) begin
            // Some sequences run with no idling on either side.
            no_idle = ($urandom_range(0, 5) == 0);
            // Steer the list size so that both empty and full come up often.
            ins_weight = (list_size < 4) ? 55 : (list_size > 12) ? 10 : 30;
            pick = $urandom_range(0, 99);
            if (pick < ins_weight) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(1, 6);
                repeat (len)
                    send_cmd($urandom_range(0, 1) ? CMD_INS_HEAD : CMD_INS_TAIL,
                             pick_value());
            end else if (pick < ins_weight + 20) begin
                if ($urandom_range(0, 3) != 0)
                    send_cmd(CMD_FIRST, pick_value());
                repeat ($urandom_range(0, 20))
                    send_cmd(CMD_NEXT, pick_value());
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 3) == 0)
                        send_cmd(CMD_FIRST, pick_value());
                    repeat ($urandom_range(0, 3))
                        send_cmd(CMD_NEXT, pick_value());
                    send_cmd(CMD_REMOVE, pick_value());
                    if ($urandom_range(0, 5) == 0)
                        send_cmd(CMD_REMOVE, pick_value());
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send_cmd(CMD_CMD_W_ANY(), pick_value());
            end
            if ($urandom_range(0, 39) == 0)
                wait_all_results();
        end
        no_idle = 1'b0;
    endtask

    // Check each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, status", 32'(m_status), 32'(ST_OK));
            end else begin
                want_res = pending_results.pop_front();
                if (m_status !== want_res.status)
                    report_mismatch("status", 32'(m_status), 32'(want_res.status));
                if (m_value_out !== want_res.value)
                    report_mismatch("value_out", m_value_out, want_res.value);
                if (m_element_count !== want_res.count)
                    report_mismatch("element_count", 32'(m_element_count),
                                    32'(want_res.count));
            end
        end
    end

    // Result side: stall a random number of cycles before each transfer.
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cmd       = CMD_INS_TAIL;
        s_value_in  = '0;
        no_idle     = 1'b0;
        mismatches  = 0;
        cmds_sent   = 0;
        cycle_count = 0;
        // Predictor state after reset: free chain 0..15, no tail, no cursor.
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_value[i] = '0;
            pool_link[i]  = 5'(i + 1);
        end
        free_ptr   = '0;
        tail_ptr   = NO_NODE;
        cursor_ptr = NO_NODE;
        prev_ptr   = NO_NODE;
        list_size  = '0;

        // Hold reset low, then release it on a falling edge.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_list();
        test_cursor_cases();
        test_fill_to_full();
        test_drain_after_pause();
        test_random_traffic(RANDOM_CMDS);

        // Drain the result queue, then let the block settle.
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/cll_pkg.sv
design/cll_ctrl.sv
design/cll_dp.sv
design/circular_list_with_cursor_top.sv
tb/tb_top.sv
